/* src/pixel_accumulate_double_buffer_macros.svh */
// Assertion macros shared by the pixel accumulator RTL.
// Needs clk_i and rst_ni in the scope of each use; empty under SYNTHESIS.
`ifndef PIXEL_ACCUMULATE_DOUBLE_BUFFER_MACROS_SVH
`define PIXEL_ACCUMULATE_DOUBLE_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

`define PAD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pad assertion failed");

`define PAD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pad assertion failed: forbidden condition");

`else

`define PAD_ASSERT(lbl, prop)

`define PAD_ASSERT_NEVER(lbl, expr)

`endif

`endif

/* src/pad_pkg.sv */
// Package for the double buffered pixel accumulator.
// Sizes, codes, payload and front/back handshake types; no dependencies.
package pad_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int BANK_WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
  localparam int X_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAME_RESET = 256;

  localparam int POS_W   = 16;
  localparam int COLOR_W = 8;
  localparam int FIELD_W = 16;
  localparam int ENTRY_W = 4 * FIELD_W;
  localparam int HIT_LSB   = 48;
  localparam int RED_LSB   = 32;
  localparam int GREEN_LSB = 16;
  localparam int BLUE_LSB  = 0;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SWAP = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RES_ADDED   = 2'd0,
    RES_DROPPED = 2'd1,
    RES_SWAPPED = 2'd2,
    RES_READ    = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SWAP = 2'd1,
    OP_READ = 2'd2,
    OP_DROP = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } pad_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] hit_count;
    logic [FIELD_W-1:0] red_sum;
    logic [FIELD_W-1:0] green_sum;
    logic [FIELD_W-1:0] blue_sum;
  } pad_out_t;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cq_head_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

/* src/pad_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pad_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pad_front.sv */
// Front end: frame registers, bounds check and entry index, command queue.
// Depends on pad_pkg and the assertion macro header.
`include "pixel_accumulate_double_buffer_macros.svh"

module pad_front import pad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  pad_in_t              in_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  back_stat_t           stat_i,
  output cq_head_t             head_o,
  input  logic                 head_pop_i
);

  logic [CFG_W-1:0] frame_w_q, frame_h_q;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic             in_frame;
  logic [Y_W+CFG_W-1:0] row_base;
  cmd_t             cmd;
  logic             accept;

  cmd_t                cq_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= CFG_W'(FRAME_RESET);
      frame_h_q <= CFG_W'(FRAME_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_w_q <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sizes above the bank geometry saturate
  assign eff_w = (int'(frame_w_q) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_w_q;
  assign eff_h = (int'(frame_h_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_h_q;

  assign in_frame = (in_i.pos_x < POS_W'(eff_w)) && (in_i.pos_y < POS_W'(eff_h));
  assign row_base = in_i.pos_y[Y_W-1:0] * eff_w;

  always_comb begin
    cmd.idx   = ADDR_W'(in_i.pos_x[X_W-1:0]) + ADDR_W'(row_base);
    cmd.red   = in_i.red_in;
    cmd.green = in_i.green_in;
    cmd.blue  = in_i.blue_in;
    case (in_i.mode)
      MODE_ADD:  cmd.op = in_frame ? OP_ADD : OP_DROP;
      MODE_SWAP: cmd.op = OP_SWAP;
      MODE_READ: cmd.op = in_frame ? OP_READ : OP_DROP;
      default:   cmd.op = OP_DROP;
    endcase
  end

  assign full_o = (cnt_q == CQ_CNT_W'(CQ_DEPTH)) || stat_i.init_busy;
  assign accept = push_i && !full_o;

  always_comb begin
    wr_ptr_d = accept ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = head_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CQ_CNT_W'(accept) - CQ_CNT_W'(head_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cq_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = cq_q[rd_ptr_q];

  `PAD_ASSERT(a_cq_pop_valid, head_pop_i |-> cnt_q != '0)
  `PAD_ASSERT(a_init_holds_queue, stat_i.init_busy |=> cnt_q == '0)

endmodule

/* src/pad_back.sv */
// Back end: two accumulation banks, bank clearing sweep, read-modify-write,
// and the result register. Depends on pad_pkg, pad_ram and the macro header.
`include "pixel_accumulate_double_buffer_macros.svh"

module pad_back import pad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cq_head_t   head_i,
  output logic       head_pop_o,
  output back_stat_t stat_o,
  input  logic       pop_i,
  output logic       empty_o,
  output pad_out_t   out_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_RDATA = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              active_q, active_d;
  logic              clr_both_q, clr_both_d;
  logic              clr_bank_q, clr_bank_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  cmd_t              cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  pad_out_t          out_q, out_d;

  logic [1:0]         ram_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata [2];
  logic [ENTRY_W-1:0] acc;
  logic               slot_free;
  logic               out_set;
  pad_out_t           res;

  pad_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_WORDS)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_we[0]),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_i.cmd.idx),
    .rdata_o (rdata[0])
  );

  pad_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_WORDS)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_we[1]),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_i.cmd.idx),
    .rdata_o (rdata[1])
  );

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    clr_both_d = clr_both_q;
    clr_bank_d = clr_bank_q;
    clr_addr_d = clr_addr_q;
    cur_d      = cur_q;
    head_pop_o = 1'b0;
    ram_we     = '0;
    waddr      = clr_addr_q;
    wdata      = '0;
    acc        = '0;
    out_set    = 1'b0;
    res        = '0;
    res.status = RES_DROPPED;

    case (state_q)
      ST_CLEAR: begin
        if (clr_both_q) begin
          ram_we = 2'b11;
        end else begin
          ram_we[clr_bank_q] = 1'b1;
        end
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(BANK_WORDS - 1)) begin
          state_d    = ST_IDLE;
          clr_both_d = 1'b0;
        end
      end
      ST_IDLE: begin
        // start only when the result slot is sure to be free at the end
        if (head_i.valid && slot_free) begin
          head_pop_o = 1'b1;
          cur_d      = head_i.cmd;
          case (head_i.cmd.op)
            OP_ADD:  state_d = ST_ADD;
            OP_READ: state_d = ST_RDATA;
            OP_SWAP: begin
              active_d   = ~active_q;
              clr_bank_d = ~active_q;
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
              out_set    = 1'b1;
              res.status = RES_SWAPPED;
            end
            default: begin
              out_set    = 1'b1;
              res.status = RES_DROPPED;
            end
          endcase
        end
      end
      ST_ADD: begin
        acc   = rdata[active_q];
        waddr = cur_q.idx;
        wdata[HIT_LSB +: FIELD_W]   = acc[HIT_LSB +: FIELD_W] + FIELD_W'(1);
        wdata[RED_LSB +: FIELD_W]   = acc[RED_LSB +: FIELD_W] + FIELD_W'(cur_q.red);
        wdata[GREEN_LSB +: FIELD_W] = acc[GREEN_LSB +: FIELD_W] + FIELD_W'(cur_q.green);
        wdata[BLUE_LSB +: FIELD_W]  = acc[BLUE_LSB +: FIELD_W] + FIELD_W'(cur_q.blue);
        ram_we[active_q] = 1'b1;
        out_set    = 1'b1;
        res.status = RES_ADDED;
        state_d    = ST_IDLE;
      end
      ST_RDATA: begin
        acc           = rdata[~active_q];
        out_set       = 1'b1;
        res.status    = RES_READ;
        res.hit_count = acc[HIT_LSB +: FIELD_W];
        res.red_sum   = acc[RED_LSB +: FIELD_W];
        res.green_sum = acc[GREEN_LSB +: FIELD_W];
        res.blue_sum  = acc[BLUE_LSB +: FIELD_W];
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_set ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);
    out_d       = out_set ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      active_q    <= 1'b0;
      clr_both_q  <= 1'b1;
      clr_bank_q  <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      clr_both_q  <= clr_both_d;
      clr_bank_q  <= clr_bank_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign stat_o.init_busy = clr_both_q;
  assign empty_o          = !out_valid_q;
  assign out_o            = out_q;

  `PAD_ASSERT_NEVER(a_slot_clobber, out_set && out_valid_q && !pop_i)
  `PAD_ASSERT(a_swap_flips, (active_d != active_q) |=> (state_q == ST_CLEAR && clr_addr_q == '0))
  `PAD_ASSERT(a_clear_is_quiet, (state_q == ST_CLEAR) |-> (!head_pop_o && !out_set))

endmodule

/* src/pixel_accumulate_double_buffer.sv */
// Top level of the double buffered pixel accumulator.
// Depends on pad_pkg, pad_front and pad_back.

// Pixel hits are summed into the active one of two 65536-entry banks (hit
// count and red, green, blue sums, 16 bits each, wrapping); a swap request
// clears the other bank and makes it active, and a read request returns an
// entry of the finished bank. While full is low the front end takes one
// request per cycle, checks it against the frame size, computes the index
// x + y * width and queues it four deep. The back end works one request at
// a time: an add or a read is popped in idle as its entry is read, then
// written back or returned; a drop or a swap is answered on the pop, and
// a swap then sweeps the whole new bank through its single write port
// while later requests wait in the queue. After reset both banks are
// swept in parallel with full high; frame size writes are always taken.
module pixel_accumulate_double_buffer import pad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  pad_in_t              in_i,
  output logic                 empty,
  input  logic                 pop,
  output pad_out_t             out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cq_head_t   head;
  logic       head_pop;
  back_stat_t stat;

  pad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .head_o      (head),
    .head_pop_i  (head_pop)
  );

  pad_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_pop_o (head_pop),
    .stat_o     (stat),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_o)
  );

endmodule

/* dv/pixel_accumulate_double_buffer_tb.sv */
// Testbench for pixel_accumulate_double_buffer: directed and random requests with
// per-request checking against a bank model. Depends on pad_pkg and the RTL only.
`timescale 1ns / 1ps

module pixel_accumulate_double_buffer_tb;
  import pad_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  pad_in_t              req_data = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  pad_out_t             res_data;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned spare_swaps = 3;

  pixel_accumulate_double_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (req_data),
    .empty       (empty),
    .pop         (pop),
    .out_o       (res_data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Bank model plus the queue of results still owed by the block.
  class accum_scoreboard;
    int unsigned      frame_w = FRAME_RESET;
    int unsigned      frame_h = FRAME_RESET;
    bit               active = 1'b0;
    bit [ENTRY_W-1:0] entries [2][BANK_WORDS];
    pad_out_t         owed_results[$];
    int unsigned      errors = 0;
    int unsigned      lines = 0;

    function int unsigned eff_width();
      return (frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w;
    endfunction

    function int unsigned eff_height();
      return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h;
    endfunction

    function void set_frame(reg_e which, logic [CFG_W-1:0] value);
      if (which == REG_FRAME_WIDTH) begin
        frame_w = 32'(value);
      end else begin
        frame_h = 32'(value);
      end
    endfunction

    function bit locate(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                        output int unsigned idx);
      int unsigned w;
      int unsigned h;
      w = eff_width();
      h = eff_height();
      idx = 0;
      if (x >= w || y >= h) return 1'b0;
      idx = x + y * w;
      return idx < BANK_WORDS;
    endfunction

    function void note_request(pad_in_t req);
      pad_out_t         res;
      int unsigned      idx;
      bit [ENTRY_W-1:0] e;
      res = '0;
      res.status = RES_DROPPED;
      case (req.mode)
        MODE_ADD: begin
          if (locate(req.pos_x, req.pos_y, idx)) begin
            e = entries[active][idx];
            e[HIT_LSB +: FIELD_W]   = e[HIT_LSB +: FIELD_W] + FIELD_W'(1);
            e[RED_LSB +: FIELD_W]   = e[RED_LSB +: FIELD_W] + FIELD_W'(req.red_in);
            e[GREEN_LSB +: FIELD_W] = e[GREEN_LSB +: FIELD_W] + FIELD_W'(req.green_in);
            e[BLUE_LSB +: FIELD_W]  = e[BLUE_LSB +: FIELD_W] + FIELD_W'(req.blue_in);
            entries[active][idx] = e;
            res.status = RES_ADDED;
          end
        end
        MODE_SWAP: begin
          // whole bank is cleared, not only the part inside the frame
          for (int i = 0; i < BANK_WORDS; i++) entries[active ^ 1'b1][i] = '0;
          active = active ^ 1'b1;
          res.status = RES_SWAPPED;
        end
        MODE_READ: begin
          if (locate(req.pos_x, req.pos_y, idx)) begin
            e = entries[active ^ 1'b1][idx];
            res.status    = RES_READ;
            res.hit_count = e[HIT_LSB +: FIELD_W];
            res.red_sum   = e[RED_LSB +: FIELD_W];
            res.green_sum = e[GREEN_LSB +: FIELD_W];
            res.blue_sum  = e[BLUE_LSB +: FIELD_W];
          end
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    task report(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      errors++;
      if (lines < 40) begin
        $display("[%0t] MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
        lines++;
      end
    endtask

    task field_check(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check_result(pad_out_t got);
      pad_out_t want;
      if (owed_results.size() == 0) begin
        report("result with no request pending", FIELD_W'(got.status), '0);
        return;
      end
      want = owed_results.pop_front();
      field_check("status", FIELD_W'(got.status), FIELD_W'(want.status));
      field_check("hit_count", got.hit_count, want.hit_count);
      field_check("red_sum", got.red_sum, want.red_sum);
      field_check("green_sum", got.green_sum, want.green_sum);
      field_check("blue_sum", got.blue_sum, want.blue_sum);
    endtask
  endclass

  accum_scoreboard board = new();

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: values are sampled as they stood just before the edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) board.check_result(res_data);
      pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_request(pad_in_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    req_data <= req;
    do @(posedge clk_i); while (full);
    board.note_request(req);
  endtask

  task automatic send_item(logic [1:0] mode, int unsigned x, int unsigned y,
                           int unsigned r, int unsigned g, int unsigned b);
    pad_in_t req;
    req.mode     = mode;
    req.pos_x    = POS_W'(x);
    req.pos_y    = POS_W'(y);
    req.red_in   = COLOR_W'(r);
    req.green_in = COLOR_W'(g);
    req.blue_in  = COLOR_W'(b);
    send_request(req);
  endtask

  // Always advances at least one edge, so push is never raised in the same step.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (board.owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame(int unsigned w, int unsigned h);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_wdata_i <= CFG_W'(w);
    @(posedge clk_i);
    board.set_frame(REG_FRAME_WIDTH, CFG_W'(w));
    cfg_idx_i   <= REG_FRAME_HEIGHT;
    cfg_wdata_i <= CFG_W'(h);
    @(posedge clk_i);
    board.set_frame(REG_FRAME_HEIGHT, CFG_W'(h));
    cfg_we_i    <= 1'b0;
  endtask

  function automatic pad_in_t random_request(bit swap);
    pad_in_t     req;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned where;
    w = board.eff_width();
    h = board.eff_height();
    pick = $urandom_range(0, 99);
    if (swap) req.mode = MODE_SWAP;
    else if (pick < 64) req.mode = MODE_ADD;
    else if (pick < 94) req.mode = MODE_READ;
    else req.mode = MODE_UNUSED;
    req.red_in   = COLOR_W'($urandom_range(0, 255));
    req.green_in = COLOR_W'($urandom_range(0, 255));
    req.blue_in  = COLOR_W'($urandom_range(0, 255));
    // saturated colors speed up sum wraparound
    if ($urandom_range(0, 5) == 0) begin
      req.red_in   = 8'hff;
      req.green_in = 8'hff;
      req.blue_in  = 8'hff;
    end
    where = $urandom_range(0, 9);
    if (w == 0 || h == 0 || where == 0) begin
      req.pos_x = POS_W'($urandom_range(0, 65535));
      req.pos_y = POS_W'($urandom_range(0, 65535));
    end else if (where == 1) begin
      req.pos_x = POS_W'(w + $urandom_range(0, 2));
      req.pos_y = POS_W'($urandom_range(0, h - 1));
    end else if (where == 2) begin
      req.pos_x = POS_W'($urandom_range(0, w - 1));
      req.pos_y = POS_W'(h + $urandom_range(0, 2));
    end else begin
      req.pos_x = POS_W'($urandom_range(0, w - 1));
      req.pos_y = POS_W'($urandom_range(0, h - 1));
    end
    return req;
  endfunction

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned n,
                           int unsigned send_pct, int unsigned recv_pct);
    bit swap;
    write_frame(w, h);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 149) == 0) drain_results();
      // one swap mid-phase so reads see this phase's hits, plus a few random ones
      swap = (i == n / 2) || (spare_swaps > 0 && $urandom_range(0, 199) == 0);
      if (swap && i != n / 2) spare_swaps--;
      send_request(random_request(swap));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 78;

    // reset frame size, 256 x 256
    send_item(MODE_ADD, 0, 0, 255, 255, 255);
    send_item(MODE_ADD, 0, 0, 0, 0, 0);
    send_item(MODE_ADD, 255, 255, 128, 1, 254);
    send_item(MODE_ADD, 256, 0, 255, 255, 255);
    send_item(MODE_ADD, 0, 256, 255, 255, 255);
    send_item(MODE_ADD, 65535, 65535, 255, 255, 255);
    send_item(MODE_UNUSED, 0, 0, 255, 255, 255);
    send_item(MODE_READ, 0, 0, 0, 0, 0);
    send_item(MODE_SWAP, 0, 0, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 0, 0, 0);
    send_item(MODE_READ, 255, 255, 0, 0, 0);
    send_item(MODE_READ, 65535, 0, 0, 0, 0);
    send_item(MODE_ADD, 0, 0, 7, 8, 9);

    // zero width: everything falls outside
    write_frame(0, 5);
    send_item(MODE_ADD, 0, 0, 1, 2, 3);
    send_item(MODE_READ, 0, 0, 0, 0, 0);

    // oversized registers saturate at the bank size
    write_frame(511, 300);
    send_item(MODE_ADD, 255, 255, 10, 20, 30);
    send_item(MODE_READ, 255, 255, 0, 0, 0);
    send_item(MODE_ADD, 256, 3, 1, 1, 1);

    write_frame(3, 2);
    send_item(MODE_ADD, 2, 1, 200, 100, 50);
    send_item(MODE_ADD, 3, 0, 1, 1, 1);
    send_item(MODE_SWAP, 0, 0, 0, 0, 0);
    send_item(MODE_READ, 2, 1, 0, 0, 0);
    send_item(MODE_READ, 2, 2, 0, 0, 0);

    run_phase(7, 5, 420, 10, 78);
    run_phase(1, 1, 330, 78, 10);
    run_phase(256, 1, 200, 78, 10);
    run_phase(200, 0, 30, 0, 0);
    run_phase(511, 511, 300, 0, 0);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (board.owed_results.size() != 0) begin
      board.report("results never returned", FIELD_W'(board.owed_results.size()), '0);
    end
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
